// ===== rtl/lcp_pkg.sv =====
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types and fixed constants of the LED cube PWM layer packer.
// ----------------------------------------------------------------------------
package lcp_pkg;

    localparam int COORD_W    = 3;
    localparam int COLOR_W    = 8;
    localparam int OBYTE_W    = 7;
    localparam int BYTE_IDX_W = 5;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [COORD_W-1:0]   pos_x;
        logic [COORD_W-1:0]   pos_y;
        logic [COORD_W-1:0]   layer_z;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
        logic [COLOR_W-1:0]   pwm_step;
    } t_in_beat;

    typedef struct packed {
        logic [OBYTE_W-1:0]    out_byte;
        logic [BYTE_IDX_W-1:0] byte_index;
        logic                  last;
    } t_out_beat;

endpackage

// ===== rtl/lcp_ram.sv =====
// ----------------------------------------------------------------------------
// lcp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 216
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lcp_lit_unit.sv =====
// ----------------------------------------------------------------------------
// lcp_lit_unit
// Compares one stored voxel's three channels against the PWM step.
// Result order: bit 2 red, bit 1 blue, bit 0 green.
// ----------------------------------------------------------------------------
module lcp_lit_unit
    import lcp_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic [3*CHANNEL_BITS-1:0] i_rgb,
    input  logic [COLOR_W-1:0]        i_step,
    output logic [2:0]                o_lit
);

    logic [COLOR_W-1:0] w_red;
    logic [COLOR_W-1:0] w_green;
    logic [COLOR_W-1:0] w_blue;

    assign w_red   = COLOR_W'(i_rgb[3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
    assign w_green = COLOR_W'(i_rgb[2*CHANNEL_BITS-1:CHANNEL_BITS]);
    assign w_blue  = COLOR_W'(i_rgb[CHANNEL_BITS-1:0]);

    assign o_lit = {w_red > i_step, w_blue > i_step, w_green > i_step};

endmodule

// ===== rtl/led_cube_pwm_layer_packer.sv =====
// ----------------------------------------------------------------------------
// led_cube_pwm_layer_packer
// RGB voxel store with a serpentine layer renderer that packs two voxels'
// PWM lit bits into each output byte.
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-------------------------------
//  input   | i_in_valid  | o_in_stall  | i_in  (t_in_beat)
//  output  | o_out_valid | i_out_stall | o_out (t_out_beat)
//
//  After reset a clearing pass zeroes all CUBE_SIZE**3 store entries (216 by
//  default), one entry a cycle, with the input stalled. A write is stored in
//  the cycle it is accepted. A render emits 18 bytes by default, each going
//  through S_RD0, S_LIT0, S_LIT1 and S_OUT (held while the output stalls):
//  each voxel goes through the single RAM read port and the shared compare
//  unit in turn. Input stalls from render accept till the last byte is taken.
// ----------------------------------------------------------------------------
module led_cube_pwm_layer_packer
    import lcp_pkg::*;
#(
    parameter int CUBE_SIZE    = 6,
    parameter int CHANNEL_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out
);

    localparam int DEPTH       = CUBE_SIZE * CUBE_SIZE * CUBE_SIZE;
    localparam int AW          = $clog2(DEPTH);
    localparam int VW          = 3 * CHANNEL_BITS;
    localparam int CW          = $clog2(CUBE_SIZE);
    localparam int LAYER_BYTES = (CUBE_SIZE * CUBE_SIZE + 1) / 2;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RD0   = 6'b000100,
        S_LIT0  = 6'b001000,
        S_LIT1  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    logic [CW-1:0]         r_y, n_y;
    logic [CW-1:0]         r_k, n_k;
    logic [COORD_W-1:0]    r_z, n_z;
    logic [COLOR_W-1:0]    r_step, n_step;
    logic [BYTE_IDX_W-1:0] r_bidx, n_bidx;
    logic                  r_tail, n_tail;
    logic [2:0]            r_hi, n_hi;
    logic                  r_out_valid, n_out_valid;
    t_out_beat             r_out, n_out;

    logic          w_in_acc;
    logic          w_wr_ok;
    logic          w_rd_ok;
    logic [CW-1:0] w_x;
    logic          w_at_end;
    logic          w_last_byte;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [VW-1:0] w_wdata;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_raddr;
    logic [VW-1:0] w_rdata;
    logic [2:0]    w_lit;

    assign w_in_acc = i_in_valid && (r_state == S_IDLE);
    assign w_wr_ok  = (int'(i_in.pos_x) < CUBE_SIZE) && (int'(i_in.pos_y) < CUBE_SIZE)
                   && (int'(i_in.layer_z) < CUBE_SIZE);
    assign w_rd_ok  = int'(i_in.layer_z) < CUBE_SIZE;

    // serpentine: odd rows run backward
    assign w_x      = r_y[0] ? (CW'(CUBE_SIZE - 1) - r_k) : r_k;
    assign w_at_end = (r_y == CW'(CUBE_SIZE - 1)) && (r_k == CW'(CUBE_SIZE - 1));
    assign w_last_byte = r_bidx == BYTE_IDX_W'(LAYER_BYTES - 1);

    assign w_raddr   = AW'((int'(w_x) * CUBE_SIZE + int'(r_y)) * CUBE_SIZE + int'(r_z));
    assign w_wr_addr = AW'((int'(i_in.pos_x) * CUBE_SIZE + int'(i_in.pos_y)) * CUBE_SIZE
                         + int'(i_in.layer_z));

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = w_in_acc && (i_in.req_type == REQ_WRITE) && w_wr_ok;
            w_waddr = w_wr_addr;
            w_wdata = {i_in.red[CHANNEL_BITS-1:0], i_in.green[CHANNEL_BITS-1:0],
                       i_in.blue[CHANNEL_BITS-1:0]};
        end
    end

    lcp_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lcp_lit_unit #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_lit (
        .i_rgb  (w_rdata),
        .i_step (r_step),
        .o_lit  (w_lit)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_y         = r_y;
        n_k         = r_k;
        n_z         = r_z;
        n_step      = r_step;
        n_bidx      = r_bidx;
        n_tail      = r_tail;
        n_hi        = r_hi;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc && (i_in.req_type == REQ_RENDER) && w_rd_ok) begin
                    n_z     = i_in.layer_z;
                    n_step  = i_in.pwm_step;
                    n_y     = '0;
                    n_k     = '0;
                    n_bidx  = '0;
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                // read of the first voxel issued; step to the second
                n_tail = w_at_end;
                if (r_k == CW'(CUBE_SIZE - 1)) begin
                    n_k = '0;
                    n_y = r_y + 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                end
                n_state = S_LIT0;
            end
            S_LIT0: begin
                n_hi = w_lit;
                if (!r_tail) begin
                    if (r_k == CW'(CUBE_SIZE - 1)) begin
                        n_k = '0;
                        n_y = r_y + 1'b1;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
                n_state = S_LIT1;
            end
            S_LIT1: begin
                n_out.out_byte   = {r_hi, 1'b0, (r_tail ? 3'b000 : w_lit)};
                n_out.byte_index = r_bidx;
                n_out.last       = w_last_byte;
                n_out_valid      = 1'b1;
                n_state          = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (w_last_byte) begin
                        n_state = S_IDLE;
                    end else begin
                        n_bidx  = r_bidx + 1'b1;
                        n_state = S_RD0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
        r_y    <= n_y;
        r_k    <= n_k;
        r_z    <= n_z;
        r_step <= n_step;
        r_bidx <= n_bidx;
        r_tail <= n_tail;
        r_hi   <= n_hi;
        r_out  <= n_out;
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== tb/led_cube_pwm_layer_packer_test.sv =====
// ----------------------------------------------------------------------------
// led_cube_pwm_layer_packer_test
// Self-checking bench: voxel writes and layer renders go in, and every
// rendered byte is compared against a local copy of the voxel store.
// ----------------------------------------------------------------------------
module led_cube_pwm_layer_packer_test;
    import lcp_pkg::*;

    localparam int CUBE_SIZE     = 6;
    localparam int CHANNEL_BITS  = 8;
    localparam int LAYER_VOXELS  = CUBE_SIZE * CUBE_SIZE;
    localparam int LAYER_BYTES   = (LAYER_VOXELS + 1) / 2;
    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 45;
    localparam int DIRECTED_ROWS = 23;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [COLOR_W-1:0] CHAN_MASK = COLOR_W'((1 << CHANNEL_BITS) - 1);

    typedef enum logic [1:0] {
        LAYER_PREDICTED,
        LAYER_DARK,
        LAYER_EMPTY
    } t_layer_check;

    typedef struct packed {
        t_in_beat     beat;
        t_layer_check check;
    } t_stim_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_stall = 1'b0;
    t_in_beat  i_in        = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out;

    logic [3*COLOR_W-1:0] voxel_rgb [CUBE_SIZE][CUBE_SIZE][CUBE_SIZE];
    t_out_beat            lit_byte_q [$];
    t_out_beat            want_beat;
    t_stim_row            directed_plan [DIRECTED_ROWS];
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;
    int                   send_pct       = 0;
    int                   recv_pct       = 0;

    led_cube_pwm_layer_packer #(
        .CUBE_SIZE    (CUBE_SIZE),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("led_cube_pwm_layer_packer regression: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_pct);
    end

    // ---------------- predictor ----------------

    // lit bits of one voxel: r, b, g from high to low
    function automatic logic [2:0] lit_bits(logic [3*COLOR_W-1:0] rgb,
                                            logic [COLOR_W-1:0] step);
        return {rgb[23:16] > step, rgb[7:0] > step, rgb[15:8] > step};
    endfunction

    function automatic logic [3*COLOR_W-1:0] serp_voxel(int pos, int z);
        int y;
        int k;
        int x;
        y = pos / CUBE_SIZE;
        k = pos % CUBE_SIZE;
        x = (y % 2 == 1) ? CUBE_SIZE - 1 - k : k;
        return voxel_rgb[x][y][z];
    endfunction

    task automatic predict_layer_bytes(input int z, input logic [COLOR_W-1:0] step);
        t_out_beat ob;
        logic [2:0] second;
        if (z >= CUBE_SIZE)
            return;
        for (int n = 0; n < LAYER_BYTES; n++) begin
            second = (2 * n + 1 < LAYER_VOXELS) ? lit_bits(serp_voxel(2 * n + 1, z), step)
                                                 : 3'b000;
            ob.out_byte   = {lit_bits(serp_voxel(2 * n, z), step), 1'b0, second};
            ob.byte_index = BYTE_IDX_W'(n);
            ob.last       = (n == LAYER_BYTES - 1);
            lit_byte_q.push_back(ob);
        end
    endtask

    task automatic take_beat(input t_in_beat b, input t_layer_check chk);
        t_out_beat ob;
        if (b.req_type == REQ_WRITE) begin
            if (b.pos_x < CUBE_SIZE && b.pos_y < CUBE_SIZE && b.layer_z < CUBE_SIZE)
                voxel_rgb[b.pos_x][b.pos_y][b.layer_z] =
                    {b.red & CHAN_MASK, b.green & CHAN_MASK, b.blue & CHAN_MASK};
        end else begin
            case (chk)
                LAYER_PREDICTED: predict_layer_bytes(b.layer_z, b.pwm_step);
                LAYER_DARK: begin
                    for (int n = 0; n < LAYER_BYTES; n++) begin
                        ob.out_byte   = '0;
                        ob.byte_index = BYTE_IDX_W'(n);
                        ob.last       = (n == LAYER_BYTES - 1);
                        lit_byte_q.push_back(ob);
                    end
                end
                LAYER_EMPTY: ;
                default: ;
            endcase
        end
    endtask

    // ---------------- stimulus ----------------

    function automatic t_in_beat wr_beat(int x, int y, int z, int r, int g, int bl);
        t_in_beat w;
        w          = t_in_beat'({$urandom, $urandom});
        w.req_type = REQ_WRITE;
        w.pos_x    = COORD_W'(x);
        w.pos_y    = COORD_W'(y);
        w.layer_z  = COORD_W'(z);
        w.red      = COLOR_W'(r);
        w.green    = COLOR_W'(g);
        w.blue     = COLOR_W'(bl);
        return w;
    endfunction

    function automatic t_in_beat rd_beat(int z, int step);
        t_in_beat w;
        w          = t_in_beat'({$urandom, $urandom});
        w.req_type = REQ_RENDER;
        w.layer_z  = COORD_W'(z);
        w.pwm_step = COLOR_W'(step);
        return w;
    endfunction

    function automatic int pick_colour();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 255;
            2:       return $urandom_range(130, 126);
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic t_in_beat random_beat(int focus_z);
        int sel;
        int z;
        int step;
        sel = $urandom_range(99);
        z   = ($urandom_range(99) < 55) ? focus_z : $urandom_range(CUBE_SIZE - 1);
        if (sel < 68)
            return wr_beat($urandom_range(CUBE_SIZE - 1), $urandom_range(CUBE_SIZE - 1), z,
                           pick_colour(), pick_colour(), pick_colour());
        if (sel < 76)
            return wr_beat($urandom_range(7), $urandom_range(7), $urandom_range(7),
                           $urandom_range(255), $urandom_range(255), $urandom_range(255));
        if (sel < 97) begin
            case ($urandom_range(9))
                0:       step = 0;
                1:       step = 255;
                2:       step = $urandom_range(130, 124);
                default: step = $urandom_range(255);
            endcase
            return rd_beat(z, step);
        end
        return rd_beat($urandom_range(7, CUBE_SIZE), $urandom_range(255));
    endfunction

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_beat(input t_in_beat b, input t_layer_check chk);
        while ($urandom_range(99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        take_beat(b, chk);
        @(negedge i_clk);
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (lit_byte_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // ---------------- checker ----------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (lit_byte_q.size() == 0) begin
                $display("%0t: beat with nothing expected, got %p", $time, o_out);
                mismatch_count++;
            end else begin
                want_beat = lit_byte_q.pop_front();
                if (o_out.out_byte !== want_beat.out_byte) begin
                    $display("%0t: out_byte expected %h got %h", $time,
                             want_beat.out_byte, o_out.out_byte);
                    mismatch_count++;
                end
                if (o_out.byte_index !== want_beat.byte_index) begin
                    $display("%0t: byte_index expected %0d got %0d", $time,
                             want_beat.byte_index, o_out.byte_index);
                    mismatch_count++;
                end
                if (o_out.last !== want_beat.last) begin
                    $display("%0t: last expected %b got %b", $time,
                             want_beat.last, o_out.last);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        int send_plan [PHASES];
        int recv_plan [PHASES];
        int focus_z;
        send_plan = '{0, 48, 0, 37};
        recv_plan = '{0, 0, 48, 37};
        foreach (voxel_rgb[x, y, z])
            voxel_rgb[x][y][z] = '0;

        // fresh store reads dark; out-of-range coordinates and layers are dropped
        directed_plan = '{
            '{rd_beat(0, 0),                      LAYER_DARK},
            '{rd_beat(5, 0),                      LAYER_DARK},
            '{wr_beat(0, 0, 0, 255, 255, 255),    LAYER_PREDICTED},
            '{wr_beat(5, 0, 0, 255, 0, 0),        LAYER_PREDICTED},
            '{wr_beat(5, 1, 0, 0, 128, 0),        LAYER_PREDICTED},
            '{wr_beat(0, 1, 0, 0, 0, 127),        LAYER_PREDICTED},
            '{wr_beat(0, 5, 0, 1, 0, 0),          LAYER_PREDICTED},
            '{wr_beat(1, 0, 0, 1, 254, 128),      LAYER_PREDICTED},
            '{wr_beat(6, 0, 0, 255, 255, 255),    LAYER_PREDICTED},
            '{wr_beat(7, 7, 7, 255, 255, 255),    LAYER_PREDICTED},
            '{wr_beat(0, 0, 6, 255, 255, 255),    LAYER_PREDICTED},
            '{rd_beat(0, 0),                      LAYER_PREDICTED},
            '{rd_beat(0, 254),                    LAYER_PREDICTED},
            '{rd_beat(0, 255),                    LAYER_DARK},
            '{rd_beat(0, 127),                    LAYER_PREDICTED},
            '{rd_beat(6, 0),                      LAYER_EMPTY},
            '{rd_beat(7, 0),                      LAYER_EMPTY},
            '{wr_beat(5, 5, 5, 170, 85, 255),     LAYER_PREDICTED},
            '{wr_beat(0, 0, 5, 128, 127, 129),    LAYER_PREDICTED},
            '{rd_beat(5, 127),                    LAYER_PREDICTED},
            '{wr_beat(0, 0, 0, 0, 0, 0),          LAYER_PREDICTED},
            '{rd_beat(0, 0),                      LAYER_PREDICTED},
            '{rd_beat(1, 0),                      LAYER_DARK}
        };

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < DIRECTED_ROWS; k++)
            send_beat(directed_plan[k].beat, directed_plan[k].check);
        wait_quiet();

        for (int ph = 0; ph < PHASES; ph++) begin
            send_pct = send_plan[ph];
            recv_pct = recv_plan[ph];
            focus_z  = $urandom_range(CUBE_SIZE - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_beat(random_beat(focus_z), LAYER_PREDICTED);
            wait_quiet();
        end

        if (mismatch_count == 0)
            $display("led_cube_pwm_layer_packer regression: pass");
        else
            $display("led_cube_pwm_layer_packer regression: fail");
        $finish;
    end

endmodule
